[design/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, character codes, token kinds and the keyword table of the
// SQL keyword tokenizer.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int OFFSET_BITS     = 16;
    localparam int FIELD_BITS      = 16;
    localparam int KIND_BITS       = 5;
    localparam int CHAR_BITS       = 8;
    localparam int CHAR_COUNT_BITS = 4;
    localparam int KW_COUNT        = 18;
    localparam int KW_MAX_LEN      = 9;
    localparam int KW_INDEX_BITS   = $clog2(KW_COUNT);

    // Result queue; depth must be a power of two so the pointers wrap
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [OFFSET_BITS-1:0]     OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [KW_COUNT-1:0]        KW_ALL     = {KW_COUNT{1'b1}};
    localparam logic [CHAR_COUNT_BITS-1:0] CHARS_MAX  = {CHAR_COUNT_BITS{1'b1}};

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_OTHER   = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_EQUALS  = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_OPEN    = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE   = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_DQUOTED = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_SQUOTED = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 5'd10;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_OPEN   = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_CLOSE  = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_BITS-1:0] CASE_GAP   = 8'h20;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_IDENT  = 6'b000010,
        MODE_NUMBER = 6'b000100,
        MODE_OTHER  = 6'b001000,
        MODE_DQ     = 6'b010000,
        MODE_SQ     = 6'b100000
    } skt_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  run_last;
        logic                  text_done;
    } skt_token_t;

    // Keyword text, right aligned: first character in the highest used byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "select", "from", "where", "table", "drop", "if",
        "exists", "insert", "into", "not", "in", "update",
        "delete", "values", "set", "returning", "join", "create"
    };

    localparam logic [CHAR_COUNT_BITS-1:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd4, 4'd5, 4'd5, 4'd4, 4'd2, 4'd6, 4'd6, 4'd4,
        4'd3, 4'd2, 4'd6, 4'd6, 4'd6, 4'd3, 4'd9, 4'd4, 4'd6
    };

    // Character idx of keyword k, or zero past its end
    function automatic logic [CHAR_BITS-1:0] kw_char(
        input logic [KW_INDEX_BITS-1:0]   k,
        input logic [CHAR_COUNT_BITS-1:0] idx
    );
        logic [CHAR_COUNT_BITS-1:0] pos;
        logic [CHAR_BITS-1:0]       ch;
        pos = KW_LEN[k] - idx - 4'd1;
        ch  = '0;
        if (idx < KW_LEN[k])
        begin
            ch = KW_TEXT[k][8*pos +: 8];
        end
        return ch;
    endfunction

endpackage

[design/skt_text_if.sv]
// ----------------------------------------------------------------------------
// skt_text_if
// Byte channel into the tokenizer: one text byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface skt_text_if;

    logic                          valid;
    logic                          ready;
    logic [skt_pkg::CHAR_BITS-1:0] text_byte;
    logic                          final_byte;

    modport source
    (
        output valid,
        output text_byte,
        output final_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  text_byte,
        input  final_byte,
        output ready
    );

endinterface

[design/skt_token_if.sv]
// ----------------------------------------------------------------------------
// skt_token_if
// Token channel out of the tokenizer: kind, start offset, length and flags.
// ----------------------------------------------------------------------------
interface skt_token_if;

    logic                           valid;
    logic                           ready;
    logic [skt_pkg::KIND_BITS-1:0]  token_kind;
    logic [skt_pkg::FIELD_BITS-1:0] start_offset;
    logic [skt_pkg::FIELD_BITS-1:0] token_length;
    logic                           run_last;
    logic                           text_done;

    modport source
    (
        output valid,
        output token_kind,
        output start_offset,
        output token_length,
        output run_last,
        output text_done,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  token_kind,
        input  start_offset,
        input  token_length,
        input  run_last,
        input  text_done,
        output ready
    );

endinterface

[design/sql_keyword_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// sql_keyword_tokenizer_core
// Streaming SQL lexer with case-insensitive keyword recognition.
// ----------------------------------------------------------------------------
// Usage:
//   text   : valid/ready channel of text bytes. final_byte marks the last byte
//            of a text; the lexer closes any open token and returns to its
//            start state (offset zero) right after it.
//   tokens : valid/ready channel of tokens (kind, start offset, length).
//            run_last flags the last token caused by one byte, text_done the
//            last token of the text's final byte.
// Output: a token is written into the result queue when the byte that ends
//   it is accepted; the tokens channel is driven from the queue head.
// Throughput: one byte per cycle. A byte yields zero, one or two tokens; the
//   tokens drain at one per cycle, so a long run of two-token bytes is paced
//   by the output side. The four-entry result queue sets this: a byte is
//   taken while at least two entries are free.
// Stall: when the receiver holds ready low the queue fills and text.ready
//   drops; nothing is lost and the lexer state simply holds.
// Reset: rst_n clears the lexer to "between tokens" at offset zero and
//   empties the result queue.
// ----------------------------------------------------------------------------
module sql_keyword_tokenizer_core
(
    input  logic              clk,
    input  logic              rst_n,
    skt_text_if.sink          text,
    skt_token_if.source       tokens
);

    // ------------------------------------------------------------------
    // Lexer state
    // ------------------------------------------------------------------
    skt_pkg::skt_mode_t                      mode_reg;
    logic [skt_pkg::OFFSET_BITS-1:0]         start_reg;
    logic [skt_pkg::OFFSET_BITS-1:0]         pos_reg;
    logic [skt_pkg::KW_COUNT-1:0]            alive_reg;
    logic [skt_pkg::CHAR_COUNT_BITS-1:0]     chars_reg;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    skt_pkg::skt_token_t                     fifo_mem [skt_pkg::FIFO_DEPTH];
    logic [skt_pkg::FIFO_PTR_BITS-1:0]       wr_ptr_reg;
    logic [skt_pkg::FIFO_PTR_BITS-1:0]       rd_ptr_reg;
    logic [skt_pkg::FIFO_CNT_BITS-1:0]       count_reg;

    logic                                    accept;
    logic                                    pop;
    logic [skt_pkg::CHAR_BITS-1:0]           c;
    logic [skt_pkg::CHAR_BITS-1:0]           lc;
    logic                                    last;

    logic                                    is_space;
    logic                                    is_delim;
    logic                                    is_punct;
    logic                                    is_letter;
    logic                                    is_digit;
    logic                                    is_dq;
    logic                                    is_sq;
    logic [skt_pkg::KIND_BITS-1:0]           single_kind;

    logic [skt_pkg::OFFSET_BITS-1:0]         pos_inc;
    logic [skt_pkg::KW_COUNT-1:0]            base_alive;
    logic [skt_pkg::CHAR_COUNT_BITS-1:0]     base_chars;
    logic [skt_pkg::KW_COUNT-1:0]            fed_alive;
    logic [skt_pkg::CHAR_COUNT_BITS-1:0]     fed_chars;

    logic                                    do_term;
    logic                                    do_single;
    logic                                    quote_start;
    skt_pkg::skt_mode_t                      mode_after;
    logic [skt_pkg::OFFSET_BITS-1:0]         start_after;
    logic [skt_pkg::KW_COUNT-1:0]            alive_after;
    logic [skt_pkg::CHAR_COUNT_BITS-1:0]     chars_after;

    logic                                    do_fin;
    skt_pkg::skt_mode_t                      fin_mode;
    logic [skt_pkg::KW_COUNT-1:0]            fin_alive;
    logic [skt_pkg::CHAR_COUNT_BITS-1:0]     fin_chars;
    logic [skt_pkg::OFFSET_BITS-1:0]         fin_start;
    logic [skt_pkg::OFFSET_BITS-1:0]         fin_end;
    logic [skt_pkg::OFFSET_BITS-1:0]         fin_len;
    logic [skt_pkg::KIND_BITS-1:0]           fin_kind;

    logic [1:0]                              push_cnt;
    skt_pkg::skt_token_t                     tok0;
    skt_pkg::skt_token_t                     tok1;
    skt_pkg::skt_token_t                     head;

    assign accept = text.valid && text.ready;
    assign pop    = tokens.valid && tokens.ready;
    assign c      = text.text_byte;
    assign last   = text.final_byte;

    // ------------------------------------------------------------------
    // Byte classification (ASCII only; bytes above 127 are "other")
    // ------------------------------------------------------------------
    assign lc = (c >= skt_pkg::CH_UPPER_A && c <= skt_pkg::CH_UPPER_Z)
              ? c + skt_pkg::CASE_GAP : c;

    assign is_space  = (c == skt_pkg::CH_SPACE) || (c == skt_pkg::CH_TAB) ||
                       (c == skt_pkg::CH_NL);
    assign is_delim  = (c == skt_pkg::CH_COMMA) || (c == skt_pkg::CH_SEMI) ||
                       (c == skt_pkg::CH_OPEN)  || (c == skt_pkg::CH_CLOSE);
    assign is_punct  = is_delim || (c == skt_pkg::CH_EQUALS);
    assign is_letter = (lc >= skt_pkg::CH_LOWER_A && lc <= skt_pkg::CH_LOWER_Z) ||
                       (c == skt_pkg::CH_UNDER);
    assign is_digit  = (c >= skt_pkg::CH_DIGIT_0 && c <= skt_pkg::CH_DIGIT_9);
    assign is_dq     = (c == skt_pkg::CH_DQUOTE);
    assign is_sq     = (c == skt_pkg::CH_SQUOTE);

    always_comb
    begin
        unique case (c)
            skt_pkg::CH_COMMA:  single_kind = skt_pkg::KIND_COMMA;
            skt_pkg::CH_SEMI:   single_kind = skt_pkg::KIND_SEMI;
            skt_pkg::CH_EQUALS: single_kind = skt_pkg::KIND_EQUALS;
            skt_pkg::CH_OPEN:   single_kind = skt_pkg::KIND_OPEN;
            skt_pkg::CH_CLOSE:  single_kind = skt_pkg::KIND_CLOSE;
            default:            single_kind = skt_pkg::KIND_OTHER;
        endcase
    end

    // Offsets stick at the top value instead of wrapping
    assign pos_inc = (pos_reg == skt_pkg::OFFSET_MAX) ? pos_reg : pos_reg + 1'b1;

    // ------------------------------------------------------------------
    // Keyword matcher: drop every keyword whose next character differs.
    // Between tokens the matcher starts fresh for the byte that opens one.
    // ------------------------------------------------------------------
    assign base_alive = (mode_reg == skt_pkg::MODE_IDLE) ? skt_pkg::KW_ALL : alive_reg;
    assign base_chars = (mode_reg == skt_pkg::MODE_IDLE) ? '0 : chars_reg;
    assign fed_chars  = (base_chars == skt_pkg::CHARS_MAX) ? base_chars
                      : base_chars + 1'b1;

    always_comb
    begin
        for (int k = 0; k < skt_pkg::KW_COUNT; k++)
        begin
            fed_alive[k] = base_alive[k] && (base_chars < skt_pkg::KW_LEN[k]) &&
                (skt_pkg::kw_char(skt_pkg::KW_INDEX_BITS'(k), base_chars) == lc);
        end
    end

    // ------------------------------------------------------------------
    // Lexer step: what this byte ends, emits and starts
    // ------------------------------------------------------------------
    always_comb
    begin
        do_term     = 1'b0;
        do_single   = 1'b0;
        quote_start = 1'b0;
        mode_after  = mode_reg;
        start_after = start_reg;
        unique case (mode_reg)
            skt_pkg::MODE_IDENT:
            begin
                // identifier ends at whitespace or , ; ( ) ; the delimiter
                // itself follows as a one-byte token
                if (is_space || is_delim)
                begin
                    do_term    = 1'b1;
                    do_single  = is_delim;
                    mode_after = skt_pkg::MODE_IDLE;
                end
            end
            skt_pkg::MODE_NUMBER, skt_pkg::MODE_OTHER:
            begin
                if (is_space)
                begin
                    do_term    = 1'b1;
                    mode_after = skt_pkg::MODE_IDLE;
                end
            end
            skt_pkg::MODE_DQ:
            begin
                if (is_dq)
                begin
                    do_term    = 1'b1;
                    mode_after = skt_pkg::MODE_IDLE;
                end
            end
            skt_pkg::MODE_SQ:
            begin
                if (is_sq)
                begin
                    do_term    = 1'b1;
                    mode_after = skt_pkg::MODE_IDLE;
                end
            end
            skt_pkg::MODE_IDLE:
            begin
                if (is_space)
                begin
                    mode_after = skt_pkg::MODE_IDLE;
                end
                else if (is_punct)
                begin
                    do_single = 1'b1;
                end
                else if (is_dq || is_sq)
                begin
                    // quoted text starts after the opening quote
                    quote_start = 1'b1;
                    mode_after  = is_dq ? skt_pkg::MODE_DQ : skt_pkg::MODE_SQ;
                    start_after = pos_inc;
                end
                else
                begin
                    start_after = pos_reg;
                    if (is_letter)
                    begin
                        mode_after = skt_pkg::MODE_IDENT;
                    end
                    else if (is_digit)
                    begin
                        mode_after = skt_pkg::MODE_NUMBER;
                    end
                    else
                    begin
                        mode_after = skt_pkg::MODE_OTHER;
                    end
                end
            end
            default:
            begin
                mode_after = skt_pkg::MODE_IDLE;
            end
        endcase
    end

    assign alive_after = quote_start ? skt_pkg::KW_ALL : fed_alive;
    assign chars_after = quote_start ? '0 : fed_chars;

    // ------------------------------------------------------------------
    // Token close: either the byte ends the token (it is not part of it),
    // or the text ends inside a token (the byte is its last character).
    // ------------------------------------------------------------------
    assign do_fin    = do_term || (last && (mode_after != skt_pkg::MODE_IDLE));
    assign fin_mode  = do_term ? mode_reg  : mode_after;
    assign fin_alive = do_term ? alive_reg : alive_after;
    assign fin_chars = do_term ? chars_reg : chars_after;
    assign fin_start = do_term ? start_reg : start_after;
    assign fin_end   = do_term ? pos_reg   : pos_inc;
    assign fin_len   = fin_end - fin_start;

    always_comb
    begin
        unique case (fin_mode)
            skt_pkg::MODE_IDENT:  fin_kind = skt_pkg::KIND_IDENT;
            skt_pkg::MODE_NUMBER: fin_kind = skt_pkg::KIND_NUMBER;
            skt_pkg::MODE_DQ:     fin_kind = skt_pkg::KIND_DQUOTED;
            skt_pkg::MODE_SQ:     fin_kind = skt_pkg::KIND_SQUOTED;
            default:              fin_kind = skt_pkg::KIND_OTHER;
        endcase
        // the first keyword in table order wins
        for (int k = skt_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (fin_alive[k] && (fin_chars == skt_pkg::KW_LEN[k]))
            begin
                fin_kind = skt_pkg::KIND_KW_BASE + skt_pkg::KIND_BITS'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Results of this byte, in order: the closed token, then the one-byte one
    // ------------------------------------------------------------------
    assign push_cnt = {1'b0, do_fin} + {1'b0, do_single};

    always_comb
    begin
        tok1.kind      = single_kind;
        tok1.start     = skt_pkg::FIELD_BITS'(pos_reg);
        tok1.length    = skt_pkg::FIELD_BITS'(1);
        tok1.run_last  = 1'b1;
        tok1.text_done = last;

        if (do_fin)
        begin
            tok0.kind   = fin_kind;
            tok0.start  = skt_pkg::FIELD_BITS'(fin_start);
            tok0.length = skt_pkg::FIELD_BITS'(fin_len);
        end
        else
        begin
            tok0.kind   = tok1.kind;
            tok0.start  = tok1.start;
            tok0.length = tok1.length;
        end
        tok0.run_last  = (push_cnt == 2'd1);
        tok0.text_done = (push_cnt == 2'd1) && last;
    end

    // ------------------------------------------------------------------
    // State registers: return to the start state after the last byte
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= skt_pkg::MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            alive_reg <= skt_pkg::KW_ALL;
            chars_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                mode_reg  <= skt_pkg::MODE_IDLE;
                start_reg <= '0;
                pos_reg   <= '0;
                alive_reg <= skt_pkg::KW_ALL;
                chars_reg <= '0;
            end
            else
            begin
                mode_reg  <= mode_after;
                start_reg <= start_after;
                pos_reg   <= pos_inc;
                alive_reg <= alive_after;
                chars_reg <= chars_after;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue: take up to two results per byte and, while tokens.ready is high, hand out one per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && (push_cnt != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= tok0;
        end
        if (accept && (push_cnt == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + skt_pkg::FIFO_PTR_BITS'(push_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg
                       + (accept ? skt_pkg::FIFO_CNT_BITS'(push_cnt) : '0)
                       - skt_pkg::FIFO_CNT_BITS'(pop);
        end
    end

    // Take a byte only while room for two results remains
    assign text.ready = (count_reg <= skt_pkg::FIFO_CNT_BITS'(skt_pkg::FIFO_DEPTH - 2));

    assign head                = fifo_mem[rd_ptr_reg];
    assign tokens.valid        = (count_reg != '0);
    assign tokens.token_kind   = head.kind;
    assign tokens.start_offset = head.start;
    assign tokens.token_length = head.length;
    assign tokens.run_last     = head.run_last;
    assign tokens.text_done    = head.text_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= skt_pkg::FIFO_CNT_BITS'(skt_pkg::FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (mode_reg == skt_pkg::MODE_IDLE) && (pos_reg == '0))
        else $error("lexer not back at start after final byte");

    a_delim_closes_ident: assert property (@(posedge clk) disable iff (!rst_n)
        accept && do_single && (mode_reg != skt_pkg::MODE_IDLE) |-> do_fin)
        else $error("delimiter after identifier did not close it");

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last |=> pos_reg >= $past(pos_reg))
        else $error("byte position went backwards");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.text_done |-> tokens.run_last)
        else $error("text_done without run_last");

endmodule
